FILE: hdl/mrass_pkg.sv
package mrass_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int ADC_BITS    = 12;

  localparam int CFG_W  = 12;
  localparam int CIDX_W = 3;
  localparam int SET_W  = 8;
  localparam int CMP_W  = (ADC_BITS > CFG_W) ? ADC_BITS : CFG_W;
  localparam int CS_W   = $clog2(NUM_SENSORS + 1);
  localparam int SEL_W  = $clog2(NUM_SENSORS + 1);
  localparam int CH_W   = $clog2(NUM_SENSORS);
  localparam int AW     = $clog2(NUM_SENSORS);

  typedef enum logic [CIDX_W-1:0] {
    CFG_SETTLE     = 3'd0,
    CFG_LO_MIN     = 3'd1,
    CFG_LO_MAX     = 3'd2,
    CFG_HI_MIN     = 3'd3,
    CFG_HI_MAX     = 3'd4,
    CFG_NEAR_LOW   = 3'd5,
    CFG_NEAR_HIGH  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_SCAN   = 2'd0,
    PH_SELECT = 2'd1,
    PH_LIN    = 2'd2,
    PH_TEMP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic tick;
    logic walk;
    logic finish;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic in_select;
    logic walk_last;
  } sts_t;

endpackage

FILE: hdl/mrass_ram.sv
module mrass_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/mrass_ctrl.sv
module mrass_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mrass_pkg::sts_t   sts,
  output mrass_pkg::cmd_t   cmd
);

  mrass_pkg::ctrl_state_t state, state_next;
  logic room;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mrass_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    room       = !out_valid || !out_stall;
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      mrass_pkg::ST_IDLE: begin
        in_stall = !room;
        if (in_valid && room) begin
          cmd.tick = 1'b1;
          if (sts.in_select) begin
            state_next = mrass_pkg::ST_WALK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      mrass_pkg::ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) begin
          state_next = mrass_pkg::ST_FINISH;
        end
      end
      mrass_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        cmd.load   = 1'b1;
        state_next = mrass_pkg::ST_IDLE;
      end
      default: begin
        state_next = mrass_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/mrass_dp.sv
module mrass_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  mrass_pkg::cmd_t                   cmd,
  output mrass_pkg::sts_t                   sts,
  input  logic                              cfg_we,
  input  logic [mrass_pkg::CIDX_W-1:0]      cfg_addr,
  input  logic [mrass_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                              conversion_done,
  input  logic [mrass_pkg::ADC_BITS-1:0]    adc_sample,
  output logic                              mux_enable,
  output logic [mrass_pkg::CH_W-1:0]        mux_channel,
  output logic                              adc_trigger,
  output logic [1:0]                        phase,
  output logic [mrass_pkg::SEL_W-1:0]       selected_sensor,
  output logic                              selection_valid,
  output logic [mrass_pkg::ADC_BITS-1:0]    adc_offset
);

  localparam int N  = mrass_pkg::NUM_SENSORS;
  localparam int AW = mrass_pkg::AW;
  localparam int CW = mrass_pkg::CMP_W;

  // configuration
  logic [mrass_pkg::SET_W-1:0] settle_ticks;
  logic [mrass_pkg::CFG_W-1:0] lo_min, lo_max, hi_min, hi_max, near_low, near_high;

  // scan state
  mrass_pkg::phase_t              phase_reg, phase_reg_next;
  logic [mrass_pkg::CS_W-1:0]     cur, cur_next;
  logic                           started, started_next;
  logic [mrass_pkg::SET_W-1:0]    settle, settle_next;
  logic                           pending, pending_next;
  logic [mrass_pkg::ADC_BITS-1:0] latched, latched_next;
  logic [mrass_pkg::ADC_BITS-1:0] offset, offset_next;
  logic [mrass_pkg::SEL_W-1:0]    chosen, chosen_next;
  logic                           mux_on, mux_on_next;
  logic [mrass_pkg::CH_W-1:0]     mux_sel, mux_sel_next;
  logic                           trigger;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  logic [mrass_pkg::ADC_BITS-1:0] ram_rdata;

  // pair walk
  logic [AW-1:0]                  wcnt;
  logic [mrass_pkg::ADC_BITS-1:0] prev, win_lo, win_hi;
  logic [mrass_pkg::SEL_W-1:0]    win_pair;
  logic [CW-1:0]                  lo_x, hi_x, wlo_x, whi_x;
  logic                           pair_hit, near_lo, near_hi;

  mrass_ram #(
    .WIDTH(mrass_pkg::ADC_BITS),
    .DEPTH(N)
  ) u_readings (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(latched_next),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks <= mrass_pkg::SET_W'(25);
      lo_min       <= mrass_pkg::CFG_W'(150);
      lo_max       <= mrass_pkg::CFG_W'(600);
      hi_min       <= mrass_pkg::CFG_W'(568);
      hi_max       <= mrass_pkg::CFG_W'(950);
      near_low     <= mrass_pkg::CFG_W'(211);
      near_high    <= mrass_pkg::CFG_W'(650);
    end else if (cfg_we) begin
      case (cfg_addr)
        mrass_pkg::CFG_SETTLE:    settle_ticks <= cfg_wdata[mrass_pkg::SET_W-1:0];
        mrass_pkg::CFG_LO_MIN:    lo_min       <= cfg_wdata;
        mrass_pkg::CFG_LO_MAX:    lo_max       <= cfg_wdata;
        mrass_pkg::CFG_HI_MIN:    hi_min       <= cfg_wdata;
        mrass_pkg::CFG_HI_MAX:    hi_max       <= cfg_wdata;
        mrass_pkg::CFG_NEAR_LOW:  near_low     <= cfg_wdata;
        mrass_pkg::CFG_NEAR_HIGH: near_high    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // one tick of the scan sequencer
  always_comb begin
    phase_reg_next = phase_reg;
    cur_next       = cur;
    started_next   = started;
    settle_next    = settle;
    pending_next   = pending | conversion_done;
    latched_next   = conversion_done ? adc_sample : latched;
    offset_next    = offset;
    mux_on_next    = mux_on;
    mux_sel_next   = mux_sel;
    trigger        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = AW'(cur - 1'b1);
    case (phase_reg)
      mrass_pkg::PH_SCAN: begin
        if (cur > mrass_pkg::CS_W'(N)) begin
          cur_next       = mrass_pkg::CS_W'(1);
          started_next   = 1'b0;
          settle_next    = '0;
          mux_sel_next   = '0;
          phase_reg_next = mrass_pkg::PH_SELECT;
        end else if (!started) begin
          if (cur == '0) begin
            mux_on_next = 1'b0;
          end else begin
            mux_sel_next = mrass_pkg::CH_W'(cur - 1'b1);
          end
          started_next = 1'b1;
        end else if (settle < settle_ticks) begin
          settle_next = settle + 1'b1;
        end else begin
          trigger = 1'b1;
          if (pending_next) begin
            pending_next = 1'b0;
            settle_next  = '0;
            started_next = 1'b0;
            if (cur == '0) begin
              offset_next = latched_next;
              mux_on_next = 1'b1;
              cur_next    = mrass_pkg::CS_W'(1);
            end else begin
              ram_we = 1'b1;
              if (cur == mrass_pkg::CS_W'(N)) begin
                cur_next       = mrass_pkg::CS_W'(1);
                phase_reg_next = mrass_pkg::PH_SELECT;
                mux_sel_next   = '0;
              end else begin
                cur_next = cur + 1'b1;
              end
            end
          end
        end
      end
      mrass_pkg::PH_SELECT: phase_reg_next = mrass_pkg::PH_LIN;
      mrass_pkg::PH_LIN:    phase_reg_next = mrass_pkg::PH_TEMP;
      default:              phase_reg_next = mrass_pkg::PH_SCAN;
    endcase
    ram_we = ram_we & cmd.tick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg <= mrass_pkg::PH_SCAN;
      cur       <= '0;
      started   <= 1'b0;
      settle    <= '0;
      pending   <= 1'b0;
      latched   <= '0;
      offset    <= '0;
      mux_on    <= 1'b1;
      mux_sel   <= '0;
    end else if (cmd.tick) begin
      phase_reg <= phase_reg_next;
      cur       <= cur_next;
      started   <= started_next;
      settle    <= settle_next;
      pending   <= pending_next;
      latched   <= latched_next;
      offset    <= offset_next;
      mux_on    <= mux_on_next;
      mux_sel   <= mux_sel_next;
    end
  end

  // walk the readings one per cycle; rdata holds reading[wcnt]
  assign sts.in_select = (phase_reg == mrass_pkg::PH_SELECT);
  assign sts.walk_last = (wcnt == AW'(N - 1));
  assign ram_raddr = (cmd.walk && !sts.walk_last) ? AW'(wcnt + 1'b1) : '0;

  always_comb begin
    lo_x  = CW'(prev);
    hi_x  = CW'(ram_rdata);
    pair_hit = (lo_x > CW'(lo_min)) && (lo_x < CW'(lo_max)) &&
               (hi_x > CW'(hi_min)) && (hi_x < CW'(hi_max)) && (lo_x < hi_x);
    wlo_x = CW'(win_lo);
    whi_x = CW'(win_hi);
    near_lo = wlo_x > CW'(near_low);
    near_hi = whi_x < CW'(near_high);
    if (win_pair == '0) begin
      chosen_next = '0;
    end else if (near_lo && !near_hi) begin
      chosen_next = win_pair;
    end else begin
      chosen_next = win_pair + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt     <= '0;
      win_pair <= '0;
      chosen   <= '0;
    end else begin
      if (cmd.tick) begin
        wcnt     <= '0;
        win_pair <= '0;
      end else if (cmd.walk) begin
        wcnt <= sts.walk_last ? '0 : AW'(wcnt + 1'b1);
        if (wcnt != '0 && pair_hit) begin
          win_pair <= mrass_pkg::SEL_W'(wcnt);
        end
      end
      if (cmd.finish) begin
        chosen <= chosen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      prev <= ram_rdata;
      if (wcnt != '0 && pair_hit) begin
        win_lo <= prev;
        win_hi <= ram_rdata;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cmd.finish) begin
        mux_enable      <= mux_on;
        mux_channel     <= mux_sel;
        adc_trigger     <= 1'b0;
        phase           <= mrass_pkg::PH_SELECT;
        selected_sensor <= chosen_next;
        selection_valid <= 1'b1;
        adc_offset      <= offset;
      end else begin
        mux_enable      <= mux_on_next;
        mux_channel     <= mux_sel_next;
        adc_trigger     <= trigger;
        phase           <= phase_reg;
        selected_sensor <= chosen;
        selection_valid <= 1'b0;
        adc_offset      <= offset_next;
      end
    end
  end

endmodule

FILE: hdl/mr_array_scan_and_select_core.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  conversion_done, adc_sample
// out      output     out_valid / out_stall mux_enable, mux_channel, adc_trigger,
//                                           phase, selected_sensor, selection_valid,
//                                           adc_offset
// cfg      input      cfg_we               cfg_addr, cfg_wdata
//
// Scan, linearize and temperature ticks reach the result register in the cycle
// after accept. A select tick first runs the pair walk, reading one stored
// reading per cycle from the single read port of the readings RAM, then finishes.
// Synchronous active-high reset; the readings RAM is not cleared.
// A new tick is taken only while the controller is idle and the result register
// is empty or being drained.
module mr_array_scan_and_select_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              conversion_done,
  input  logic [mrass_pkg::ADC_BITS-1:0]    adc_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              mux_enable,
  output logic [mrass_pkg::CH_W-1:0]        mux_channel,
  output logic                              adc_trigger,
  output logic [1:0]                        phase,
  output logic [mrass_pkg::SEL_W-1:0]       selected_sensor,
  output logic                              selection_valid,
  output logic [mrass_pkg::ADC_BITS-1:0]    adc_offset,
  input  logic                              cfg_we,
  input  logic [mrass_pkg::CIDX_W-1:0]      cfg_addr,
  input  logic [mrass_pkg::CFG_W-1:0]       cfg_wdata
);

  mrass_pkg::cmd_t cmd;
  mrass_pkg::sts_t sts;

  mrass_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrass_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .conversion_done(conversion_done),
    .adc_sample     (adc_sample),
    .mux_enable     (mux_enable),
    .mux_channel    (mux_channel),
    .adc_trigger    (adc_trigger),
    .phase          (phase),
    .selected_sensor(selected_sensor),
    .selection_valid(selection_valid),
    .adc_offset     (adc_offset)
  );

`ifndef ASSERT_OFF
  a_sel_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (selection_valid == (phase == mrass_pkg::PH_SELECT)))
    else $error("selection_valid does not match phase");

  a_trig_scan: assert property (@(posedge clk) disable iff (rst)
    out_valid && adc_trigger |-> (phase == mrass_pkg::PH_SCAN))
    else $error("trigger outside scan phase");

  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.walk || cmd.finish |-> in_stall)
    else $error("tick accepted during pair walk");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    cmd.walk && sts.walk_last |=> cmd.finish && cmd.load)
    else $error("pair walk did not finish");
`endif

endmodule
